/* rtl/core/cpe_pkg.sv */
// ----------------------------------------------------------------------------
// cpe_pkg
// shared widths, codes and reset values for the characteristic polynomial
// evaluation store
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int NUM_POINTS_DEF = 64;

    localparam int MOD_W  = 62;
    localparam int ELEM_W = 60;
    localparam int BITS_W = 6;
    localparam int PIU_W  = 7;
    localparam int IDX_W  = 6;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 2;
    localparam int WIDE_W = 64;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [CFG_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [CFG_W-1:0] REG_BITS    = 2'd1;
    localparam logic [CFG_W-1:0] REG_POINTS  = 2'd2;

    localparam logic [MOD_W-1:0]  MODULUS_RST = 62'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [BITS_W-1:0] BITS_RST    = 6'd32;
    localparam logic [PIU_W-1:0]  POINTS_RST  = 7'd64;

endpackage

/* rtl/core/char_poly_eval_update.sv */
// ----------------------------------------------------------------------------
// char_poly_eval_update
// keeps a set's characteristic polynomial evaluated at sample points
// 2^bits + i + 1 modulo a prime; insert, remove and read one value
// ----------------------------------------------------------------------------
// usage
// - input channel (i_in_valid / o_in_ready) carries mode, element and
//   point_index; a transfer happens when both are high
// - output channel (o_out_valid / i_out_ready) returns one value per read
// - config channel (i_cfg_valid / o_cfg_ready) writes modulus, element
//   bits and points in use; always ready, write only while idle
// - a read waits in ST_RD while an earlier result is still held, then
//   registers its value into the output register
// - an insert does, per point in use, two 64-step remainders and a
//   62-bit double-and-add multiply, all on the one shared modular
//   add/subtract unit
// - a remove adds an extended euclid per point; each euclid step is a
//   64-step division plus a 62-bit multiply, and a 62-bit modulus
//   needs up to about 90 steps
// - the block takes one item at a time; o_in_ready is low while working
// - reset sets registers to defaults and marks every stored value as one
//   through per-entry valid bits, so no clearing pass is needed
// - a stalled receiver holds the read result in the output register
// ----------------------------------------------------------------------------
module char_poly_eval_update #(
    parameter int NUM_POINTS = cpe_pkg::NUM_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cpe_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [cpe_pkg::MOD_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cpe_pkg::MODE_W-1:0]    i_mode,
    input  logic [cpe_pkg::ELEM_W-1:0]    i_element,
    input  logic [cpe_pkg::IDX_W-1:0]     i_point_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cpe_pkg::MOD_W-1:0]     o_eval_value,
    output logic [cpe_pkg::IDX_W-1:0]     o_read_index
);

    localparam int MW = cpe_pkg::MOD_W;
    localparam int WW = cpe_pkg::WIDE_W;
    localparam int PW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int CW = $clog2(NUM_POINTS + 1);
    localparam int IW = (PW > cpe_pkg::IDX_W) ? PW : cpe_pkg::IDX_W;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_RD   = 14'b00000000000010,
        ST_REM  = 14'b00000000000100,
        ST_MUL  = 14'b00000000001000,
        ST_E0   = 14'b00000000010000,
        ST_PT   = 14'b00000000100000,
        ST_PT2  = 14'b00000001000000,
        ST_EV   = 14'b00000010000000,
        ST_EV2  = 14'b00000100000000,
        ST_ECHK = 14'b00001000000000,
        ST_EQ   = 14'b00010000000000,
        ST_ES   = 14'b00100000000000,
        ST_WB   = 14'b01000000000000,
        ST_NXT  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    logic [MW-1:0]                  r_m;
    logic [cpe_pkg::BITS_W-1:0]     r_bits;
    logic [cpe_pkg::PIU_W-1:0]      r_piu;

    logic [MW-1:0]                  r_mem [NUM_POINTS];
    logic [NUM_POINTS-1:0]          r_vld;
    logic [MW-1:0]                  r_rdata;
    logic                           r_rvld;

    logic [cpe_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [CW-1:0]                  r_i, n_i, r_npts, n_npts;
    logic [WW-1:0]                  r_x, n_x, r_r, n_r, r_q, n_q;
    logic [6:0]                     r_cnt, n_cnt;
    logic                           r_div_m, n_div_m;
    logic [MW-1:0]                  r_e, n_e, r_term, n_term, r_ev, n_ev;
    logic [MW-1:0]                  r_a, n_a, r_b, n_b, r_acc, n_acc;
    logic                           r_ph, n_ph;
    logic [MW-1:0]                  r_r0, n_r0, r_r1, n_r1, r_s0, n_s0, r_s1, n_s1, r_t, n_t;

    logic                           r_out_valid, n_out_valid;
    logic [MW-1:0]                  r_out_val, n_out_val;
    logic [cpe_pkg::IDX_W-1:0]      r_out_idx, n_out_idx, r_ridx, n_ridx;
    logic                           r_oob, n_oob;

    logic                           w_in_xfer;
    logic [IW-1:0]                  w_idx_ext;
    logic [PW-1:0]                  w_raddr;
    logic                           w_rd_en;
    logic                           w_wr_en;
    logic [WW-1:0]                  w_mask;
    logic [CW-1:0]                  w_npts;

    logic [WW-1:0]                  u_x, u_y, u_d, u_res;
    logic                           u_sub, u_ge;
    logic [WW:0]                    u_sum, u_dif;

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_eval_value = r_out_val;
    assign o_read_index = r_out_idx;

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_idx_ext = IW'(i_point_index);
    assign w_raddr   = (r_state == ST_IDLE) ? w_idx_ext[PW-1:0] : r_i[PW-1:0];
    assign w_rd_en   = (r_state == ST_IDLE) || (r_state == ST_PT2);
    assign w_wr_en   = (r_state == ST_WB);
    assign w_mask    = (WW'(1) << r_bits) - WW'(1);
    assign w_npts    = (32'(r_piu) > NUM_POINTS) ? CW'(NUM_POINTS) : CW'(r_piu);

    // shared modular add / subtract unit
    assign u_sum = {1'b0, u_x} + {1'b0, u_y};
    assign u_dif = {1'b0, u_x} - {1'b0, u_y};
    assign u_ge  = (u_sum >= {1'b0, u_d});

    always_comb begin
        if (u_sub) begin
            u_res = u_dif[WW] ? (u_dif[WW-1:0] + u_d) : u_dif[WW-1:0];
        end else begin
            u_res = u_ge ? (u_sum[WW-1:0] - u_d) : u_sum[WW-1:0];
        end
    end

    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_d   = WW'(r_m);
        u_sub = 1'b0;
        case (r_state)
            ST_REM: begin
                u_x = {r_r[WW-2:0], 1'b0};
                u_y = WW'(r_x[WW-1]);
                u_d = r_div_m ? WW'(r_m) : WW'(r_r1);
            end
            ST_MUL: begin
                u_x = r_ph ? WW'(r_a) : WW'(r_acc);
                u_y = WW'(r_a);
            end
            ST_PT2: begin
                u_x   = r_r;
                u_y   = WW'(r_e);
                u_sub = 1'b1;
            end
            ST_ES: begin
                u_x   = WW'(r_s0);
                u_y   = WW'(r_acc);
                u_sub = 1'b1;
            end
            default: begin
                u_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_mode      = r_mode;
        n_i         = r_i;
        n_npts      = r_npts;
        n_x         = r_x;
        n_r         = r_r;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_div_m     = r_div_m;
        n_e         = r_e;
        n_term      = r_term;
        n_ev        = r_ev;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_ph        = r_ph;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_t         = r_t;
        n_ridx      = r_ridx;
        n_oob       = r_oob;
        n_out_val   = r_out_val;
        n_out_idx   = r_out_idx;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_mode == cpe_pkg::MODE_READ) begin
                        n_ridx  = i_point_index;
                        n_oob   = !(32'(i_point_index) < NUM_POINTS);
                        n_state = ST_RD;
                    end else if ((i_mode == cpe_pkg::MODE_INSERT ||
                                  i_mode == cpe_pkg::MODE_REMOVE) &&
                                 r_m >= MW'(2) && w_npts != '0) begin
                        n_mode  = i_mode;
                        n_npts  = w_npts;
                        n_i     = '0;
                        n_x     = WW'(i_element) & w_mask;
                        n_r     = '0;
                        n_q     = '0;
                        n_cnt   = '0;
                        n_div_m = 1'b1;
                        n_ret   = ST_E0;
                        n_state = ST_REM;
                    end
                end
            end
            ST_RD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_ridx;
                    n_out_val   = r_oob ? '0 : (r_rvld ? r_rdata : MW'(1));
                    n_state     = ST_IDLE;
                end
            end
            ST_REM: begin
                n_r   = u_res;
                n_q   = {r_q[WW-2:0], u_ge};
                n_x   = {r_x[WW-2:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(WW - 1)) begin
                    n_state = r_ret;
                end
            end
            ST_MUL: begin
                if (!r_ph) begin
                    if (r_b[0]) begin
                        n_acc = u_res[MW-1:0];
                    end
                    n_ph = 1'b1;
                end else begin
                    n_a   = u_res[MW-1:0];
                    n_b   = r_b >> 1;
                    n_ph  = 1'b0;
                    n_cnt = r_cnt + 7'd1;
                    if (r_cnt == 7'(MW - 1)) begin
                        n_state = r_ret;
                    end
                end
            end
            ST_E0: begin
                n_e     = r_r[MW-1:0];
                n_state = ST_PT;
            end
            ST_PT: begin
                n_x     = (WW'(1) << r_bits) + WW'(r_i) + WW'(1);
                n_r     = '0;
                n_q     = '0;
                n_cnt   = '0;
                n_div_m = 1'b1;
                n_ret   = ST_PT2;
                n_state = ST_REM;
            end
            ST_PT2: begin
                n_term  = u_res[MW-1:0];
                n_state = ST_EV;
            end
            ST_EV: begin
                n_x     = r_rvld ? WW'(r_rdata) : WW'(1);
                n_r     = '0;
                n_q     = '0;
                n_cnt   = '0;
                n_div_m = 1'b1;
                n_ret   = ST_EV2;
                n_state = ST_REM;
            end
            ST_EV2: begin
                n_ev = r_r[MW-1:0];
                if (r_mode == cpe_pkg::MODE_INSERT) begin
                    n_a     = r_r[MW-1:0];
                    n_b     = r_term;
                    n_acc   = '0;
                    n_ph    = 1'b0;
                    n_cnt   = '0;
                    n_ret   = ST_WB;
                    n_state = ST_MUL;
                end else begin
                    n_r0    = r_m;
                    n_r1    = r_term;
                    n_s0    = '0;
                    n_s1    = MW'(1);
                    n_state = ST_ECHK;
                end
            end
            ST_ECHK: begin
                if (r_r1 == '0) begin
                    if (r_r0 == MW'(1)) begin
                        n_a     = r_ev;
                        n_b     = r_s0;
                        n_acc   = '0;
                        n_ph    = 1'b0;
                        n_cnt   = '0;
                        n_ret   = ST_WB;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_NXT;
                    end
                end else begin
                    n_x     = WW'(r_r0);
                    n_r     = '0;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_div_m = 1'b0;
                    n_ret   = ST_EQ;
                    n_state = ST_REM;
                end
            end
            ST_EQ: begin
                n_t     = r_r[MW-1:0];
                n_a     = r_s1;
                n_b     = r_q[MW-1:0];
                n_acc   = '0;
                n_ph    = 1'b0;
                n_cnt   = '0;
                n_ret   = ST_ES;
                n_state = ST_MUL;
            end
            ST_ES: begin
                n_r0    = r_r1;
                n_r1    = r_t;
                n_s0    = r_s1;
                n_s1    = u_res[MW-1:0];
                n_state = ST_ECHK;
            end
            ST_WB: begin
                n_state = ST_NXT;
            end
            ST_NXT: begin
                if (r_i + CW'(1) == r_npts) begin
                    n_state = ST_IDLE;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = ST_PT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_m         <= cpe_pkg::MODULUS_RST;
            r_bits      <= cpe_pkg::BITS_RST;
            r_piu       <= cpe_pkg::POINTS_RST;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            if (w_wr_en) begin
                r_vld[r_i[PW-1:0]] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cpe_pkg::REG_MODULUS: r_m    <= i_cfg_data;
                    cpe_pkg::REG_BITS:    r_bits <= i_cfg_data[cpe_pkg::BITS_W-1:0];
                    cpe_pkg::REG_POINTS:  r_piu  <= i_cfg_data[cpe_pkg::PIU_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // evaluation memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_i[PW-1:0]] <= r_acc;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_raddr];
            r_rvld  <= r_vld[w_raddr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_i       <= n_i;
        r_npts    <= n_npts;
        r_x       <= n_x;
        r_r       <= n_r;
        r_q       <= n_q;
        r_cnt     <= n_cnt;
        r_div_m   <= n_div_m;
        r_e       <= n_e;
        r_term    <= n_term;
        r_ev      <= n_ev;
        r_a       <= n_a;
        r_b       <= n_b;
        r_acc     <= n_acc;
        r_ph      <= n_ph;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_s0      <= n_s0;
        r_s1      <= n_s1;
        r_t       <= n_t;
        r_ridx    <= n_ridx;
        r_oob     <= n_oob;
        r_out_val <= n_out_val;
        r_out_idx <= n_out_idx;
    end

endmodule
